// File: src/chained_hash_table_engine_top_macros.svh
// assertion macros shared by the hash table engine checkers
// expects clk and arst_n in the scope of every use
`ifndef CHAINED_HASH_TABLE_ENGINE_TOP_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define CHTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/chte_pkg.sv
// shared types and codes for the chained hash table engine
// no dependencies
package chte_pkg;

	localparam int KEY_W    = 31;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 3;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SEARCH = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_REPLACED  = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FOUND     = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MOD,
		S_ROW,
		S_SCAN,
		S_EXEC
	} fsm_t;

	// read and write strobes toward the entry store
	typedef struct packed {
		logic row_rd;
		logic kv_rd;
		logic row_we;
		logic kv_we;
	} store_cmd_t;

endpackage

// File: src/chte_store.sv
// entry store: per-bucket valid rows and key/value words, registered reads
// depends on chte_pkg
module chte_store #(
	parameter int BUCKETS = 16,
	parameter int WAYS    = 4
) (
	input  logic                                  clk,
	input  chte_pkg::store_cmd_t                  cmd,
	input  logic [$clog2(BUCKETS)-1:0]            row_addr,
	input  logic [WAYS-1:0]                       row_wdata,
	input  logic [$clog2(BUCKETS)+((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] kv_addr,
	input  logic [chte_pkg::KEY_W-1:0]            kv_wkey,
	input  logic [chte_pkg::VAL_W-1:0]            kv_wval,
	output logic [WAYS-1:0]                       rd_row,
	output logic [chte_pkg::KEY_W-1:0]            rd_key,
	output logic [chte_pkg::VAL_W-1:0]            rd_val
);
	import chte_pkg::*;

	localparam int WW       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int KV_DEPTH = BUCKETS * (2 ** WW);

	logic [WAYS-1:0]          row_mem [BUCKETS];
	logic [KEY_W+VAL_W-1:0]   kv_mem  [KV_DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.row_we) begin
			row_mem[row_addr] <= row_wdata;
		end
		if (cmd.row_rd) begin
			rd_row <= row_mem[row_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.kv_we) begin
			kv_mem[kv_addr] <= {kv_wval, kv_wkey};
		end
		if (cmd.kv_rd) begin
			{rd_val, rd_key} <= kv_mem[kv_addr];
		end
	end

endmodule

// File: src/chained_hash_table_engine_top.sv
// top level of the chained hash table engine: sequencer, shared multiplier,
// way compare and result register; depends on chte_pkg and chte_store
//
// Key/value table with BUCKETS buckets of WAYS entries, bucket = key mod BUCKETS.
// Request channel (s_axis_*): tuser carries the request kind (insert, remove,
// search), tdata carries key and value. Result channel (m_axis_*): tdata is the
// found value, tuser the status code and the table-empty flag.
// One request is in flight at a time. A request passes through the shared
// multiplier (reciprocal estimate, then back-multiply), the modulo correction
// and the row read, then the key compare steps through the ways one at a time
// (it stops at the first hit), and then the store is updated. The next request
// is not taken until the current one is through with its store update.
// After reset the valid rows are swept clear, one bucket per cycle, and
// s_axis_tready stays low until the sweep is done.
// A finished result waits in the output register; the next request is still
// accepted meanwhile, but its store update waits until the result is taken.
module chained_hash_table_engine_top #(
	parameter int BUCKETS = 16,
	parameter int WAYS    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [30:0] key, [62:31] value, [63] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] found_value
	output logic [3:0]  m_axis_tuser    // [2:0] status, [3] table_empty
);
	import chte_pkg::*;

	localparam int BW  = $clog2(BUCKETS);
	localparam int BW1 = BW + 1;
	localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CW  = $clog2(BUCKETS * WAYS + 1);
	localparam int PW  = 2 * KEY_W;
	// floor(2^31 / BUCKETS): quotient estimate is exact or one low
	localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << KEY_W) / BUCKETS);
	localparam logic [KEY_W-1:0] BKT_MUL = KEY_W'(BUCKETS);
	localparam logic [BW:0]      BKT_MOD = BW1'(BUCKETS);
	localparam logic [BW-1:0]    LAST_BKT = BW'(BUCKETS - 1);
	localparam logic [WW-1:0]    LAST_WAY = WW'(WAYS - 1);

	fsm_t state_q, state_d;

	logic [BW-1:0]     clr_idx_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	logic              out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [VAL_W-1:0]  out_fv_q;
	logic              out_empty_q;

	req_t              req_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [PW-1:0]     prod_q;
	logic [BW-1:0]     bucket_q;
	logic [WW-1:0]     way_q;
	logic              hit_q;
	logic [WW-1:0]     hit_way_q;
	logic [VAL_W-1:0]  hit_val_q;
	logic              free_q;
	logic [WW-1:0]     free_way_q;

	logic              s_fire;
	logic              out_free;
	logic              exec_fire;
	logic              hit_now;
	logic              last_way;

	logic [KEY_W-1:0]  mult_a;
	logic [KEY_W-1:0]  mult_b;
	logic [PW-1:0]     prod_d;
	logic [KEY_W-1:0]  diff;
	logic [BW:0]       rem;
	logic [BW:0]       rem_fix;

	store_cmd_t        cmd;
	logic [BW-1:0]     row_addr;
	logic [WAYS-1:0]   row_wdata;
	logic [BW+WW-1:0]  kv_addr;
	logic [WW-1:0]     kv_way;
	logic [WAYS-1:0]   rd_row;
	logic [KEY_W-1:0]  rd_key;
	logic [VAL_W-1:0]  rd_val;
	logic [WAYS-1:0]   way_bit;
	status_t           status_d;
	logic [VAL_W-1:0]  fv_d;

	chte_store #(
		.BUCKETS (BUCKETS),
		.WAYS    (WAYS)
	) u_store (
		.clk       (clk),
		.cmd       (cmd),
		.row_addr  (row_addr),
		.row_wdata (row_wdata),
		.kv_addr   (kv_addr),
		.kv_wkey   (key_q),
		.kv_wval   (val_q),
		.rd_row    (rd_row),
		.rd_key    (rd_key),
		.rd_val    (rd_val)
	);

	assign s_fire    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign hit_now   = rd_row[way_q] && (rd_key == key_q);
	assign last_way  = (way_q == LAST_WAY);

	// shared multiplier: key * reciprocal, then quotient * bucket count
	assign mult_a = (state_q == S_MUL2) ? prod_q[PW-1:KEY_W] : key_q;
	assign mult_b = (state_q == S_MUL2) ? BKT_MUL : RECIP;
	assign prod_d = mult_a * mult_b;

	// remainder is below twice the bucket count, one subtract fixes it
	assign diff    = key_q - prod_q[KEY_W-1:0];
	assign rem     = diff[BW:0];
	assign rem_fix = (rem >= BKT_MOD) ? (rem - BKT_MOD) : rem;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_idx_q == LAST_BKT) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_fire) state_d = S_MUL1;
			end
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_MOD;
			S_MOD:  state_d = S_ROW;
			S_ROW:  state_d = S_SCAN;
			S_SCAN: begin
				if (hit_now || last_way) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and store control
	always_comb begin
		s_axis_tready = 1'b0;
		exec_fire     = 1'b0;
		cmd           = '0;
		row_addr      = bucket_q;
		row_wdata     = rd_row;
		kv_way        = '0;
		status_d      = ST_NOT_FOUND;
		fv_d          = '0;
		count_d       = count_q;
		way_bit       = WAYS'(1) << (hit_q ? hit_way_q : free_way_q);
		unique case (state_q)
			S_CLEAR: begin
				cmd.row_we = 1'b1;
				row_addr   = clr_idx_q;
				row_wdata  = '0;
			end
			S_IDLE: begin
				s_axis_tready = 1'b1;
			end
			S_ROW: begin
				cmd.row_rd = 1'b1;
				cmd.kv_rd  = 1'b1;
			end
			S_SCAN: begin
				cmd.kv_rd = 1'b1;
				kv_way    = way_q + 1'b1;
			end
			S_EXEC: begin
				exec_fire = out_free;
				unique case (req_q)
					REQ_INSERT: begin
						if (hit_q) begin
							status_d  = ST_REPLACED;
							kv_way    = hit_way_q;
							cmd.kv_we = out_free;
						end else if (free_q) begin
							status_d   = ST_INSERTED;
							kv_way     = free_way_q;
							cmd.kv_we  = out_free;
							cmd.row_we = out_free;
							row_wdata  = rd_row | way_bit;
							count_d    = count_q + CW'(1);
						end else begin
							status_d = ST_FULL;
						end
					end
					REQ_REMOVE: begin
						if (hit_q) begin
							status_d   = ST_REMOVED;
							cmd.row_we = out_free;
							row_wdata  = rd_row & ~way_bit;
							count_d    = count_q - CW'(1);
						end
					end
					REQ_SEARCH: begin
						if (hit_q) begin
							status_d = ST_FOUND;
							fv_d     = hit_val_q;
						end
					end
					default: status_d = ST_NOT_FOUND;
				endcase
			end
			default: begin
			end
		endcase
		kv_addr = {bucket_q, kv_way};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (exec_fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			req_q <= req_t'(s_axis_tuser);
			key_q <= s_axis_tdata[KEY_W-1:0];
			val_q <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
		end
		if (state_q == S_MUL1 || state_q == S_MUL2) begin
			prod_q <= prod_d;
		end
		if (state_q == S_MOD) begin
			bucket_q <= rem_fix[BW-1:0];
		end
		if (state_q == S_ROW) begin
			way_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end
		if (state_q == S_SCAN) begin
			way_q <= way_q + 1'b1;
			if (!free_q && !rd_row[way_q]) begin
				free_q     <= 1'b1;
				free_way_q <= way_q;
			end
			if (hit_now) begin
				hit_q     <= 1'b1;
				hit_way_q <= way_q;
				hit_val_q <= rd_val;
			end
		end
		if (exec_fire) begin
			out_status_q <= status_d;
			out_fv_q     <= fv_d;
			out_empty_q  <= (count_d == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_fv_q;
	assign m_axis_tuser  = {out_empty_q, out_status_q};

endmodule

// File: src/chte_port_checker.sv
// port-level checks for the chained hash table engine, bound to the top level
// depends on chte_pkg and chained_hash_table_engine_top_macros.svh
`include "chained_hash_table_engine_top_macros.svh"

module chte_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [63:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser
);
	import chte_pkg::*;

	// a stalled result beat stays up
	`CHTE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")

	// one request at a time: busy right after an accepted beat
	`CHTE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")

	// value field is zero unless a search hit
	`CHTE_ASSERT_NOW(a_value_zero, m_axis_tvalid && (m_axis_tuser[2:0] != ST_FOUND), m_axis_tdata == 32'd0, "nonzero value without search hit")

	// a fresh insert can never leave the table empty
	`CHTE_ASSERT_NOW(a_insert_not_empty, m_axis_tvalid && (m_axis_tuser[2:0] == ST_INSERTED), !m_axis_tuser[3], "empty flag set after insert")

endmodule

bind chained_hash_table_engine_top chte_port_checker u_port_checker (.*);
